[sv/mcc_pkg.sv]
// Package: Morse code table, character constants and lookup functions for the codec.
`timescale 1ns / 1ps
`default_nettype none
package mcc_pkg;

  localparam int CODE_COUNT   = 36;
  localparam int LETTER_COUNT = 26;
  localparam int MAX_ELEMENTS = 5;

  localparam logic [7:0] LETTER_BASE = 8'd65;
  localparam logic [7:0] DIGIT_BASE  = 8'd48;
  localparam logic [7:0] LOWER_BASE  = 8'd97;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] CHR_DOT     = 8'h2E;
  localparam logic [7:0] CHR_DASH    = 8'h2D;
  localparam logic [7:0] CHR_SPACE   = 8'h20;

  typedef struct packed {
    logic       hit;
    logic [2:0] len;
    logic [4:0] pat;
  } enc_code_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] chr;
  } dec_char_t;

  // first element in bit 4, dash is 1
  localparam logic [4:0] CODE_PAT [CODE_COUNT] = '{
    5'b01000, 5'b10000, 5'b10100, 5'b10000, 5'b00000, 5'b00100, 5'b11000,
    5'b00000, 5'b00000, 5'b01110, 5'b10100, 5'b01000, 5'b11000, 5'b10000,
    5'b11100, 5'b01100, 5'b11010, 5'b01000, 5'b00000, 5'b10000, 5'b00100,
    5'b00010, 5'b01100, 5'b10010, 5'b10110, 5'b11000,
    5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001, 5'b00000, 5'b10000,
    5'b11000, 5'b11100, 5'b11110
  };

  localparam logic [2:0] CODE_LEN [CODE_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  function automatic logic [7:0] code_char(input int k);
    if (k < LETTER_COUNT) begin
      return LETTER_BASE + 8'(k);
    end
    return DIGIT_BASE + 8'(k - LETTER_COUNT);
  endfunction

  function automatic enc_code_t encode_lookup(input logic [7:0] c);
    logic [7:0] up;
    enc_code_t  res;
    up  = c;
    res = '0;
    if (c >= LOWER_BASE && c <= LOWER_BASE + 8'd25) begin
      up = c - CASE_OFFSET;
    end
    for (int k = 0; k < CODE_COUNT; k++) begin
      if (up == code_char(k)) begin
        res.hit = 1'b1;
        res.len = res.len | CODE_LEN[k];
        res.pat = res.pat | CODE_PAT[k];
      end
    end
    return res;
  endfunction

  function automatic dec_char_t decode_lookup(input logic [2:0] len, input logic [4:0] pat);
    dec_char_t res;
    res = '0;
    for (int k = 0; k < CODE_COUNT; k++) begin
      if (len == CODE_LEN[k] && pat == CODE_PAT[k]) begin
        res.hit = 1'b1;
        res.chr = res.chr | code_char(k);
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[sv/morse_code_codec_unit.sv]
// Streaming International Morse codec for letters and digits, encode and decode.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted character is translated into a job register, and the output
// register then sends one beat per cycle while out_tready allows: a letter or
// digit in encode mode takes its element count plus one beats (two to six beats), a
// space one beat, and any other character none. A new character is taken in the
// cycle the current job sends its last beat, leaving no gap between characters.
// Decode mode gathers dots and dashes into a group and sends one beat, with tlast
// set, when a space closes a group that matches a letter or digit. cfg_data bit 0
// selects the direction (0 encode, 1 decode); write it only while the block is idle.
module morse_code_codec_unit
  import mcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,     // direction
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,     // [7:0] in_char
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,    // [7:0] out_char
  output logic            out_tlast     // last
);

  logic       direction_r;
  logic [4:0] grp_pat_r, grp_pat_nxt;
  logic [2:0] grp_len_r, grp_len_nxt;
  logic       grp_bad_r, grp_bad_nxt;

  logic       job_valid_r, job_valid_nxt;
  logic [4:0] job_pat_r, job_pat_nxt;
  logic [2:0] job_rem_r, job_rem_nxt;
  logic [7:0] job_char_r, job_char_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;

  logic       in_fire, out_load, job_done;
  logic       is_elem;
  logic [4:0] grp_aligned;
  enc_code_t  enc;
  dec_char_t  dec;

  assign cfg_ready  = 1'b1;
  assign out_load   = job_valid_r && (!out_valid_r || out_tready);
  assign job_done   = out_load && (job_rem_r == 3'd0);
  assign in_tready  = !job_valid_r || job_done;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign is_elem     = (in_tdata == CHR_DOT) || (in_tdata == CHR_DASH);
  assign grp_aligned = 5'(grp_pat_r << (3'd5 - grp_len_r));
  assign enc         = encode_lookup(in_tdata);
  assign dec         = decode_lookup(grp_len_r, grp_aligned);

  // translate the accepted character into a job and update the group
  always_comb begin
    grp_pat_nxt   = grp_pat_r;
    grp_len_nxt   = grp_len_r;
    grp_bad_nxt   = grp_bad_r;
    job_valid_nxt = job_valid_r && !job_done;
    job_pat_nxt   = job_pat_r;
    job_rem_nxt   = job_rem_r;
    job_char_nxt  = job_char_r;
    if (out_load && job_rem_r != 3'd0) begin
      job_pat_nxt = {job_pat_r[3:0], 1'b0};
      job_rem_nxt = job_rem_r - 3'd1;
    end
    if (in_fire) begin
      job_valid_nxt = 1'b0;
      job_pat_nxt   = '0;
      job_rem_nxt   = '0;
      job_char_nxt  = CHR_SPACE;
      if (!direction_r) begin
        if (enc.hit) begin
          job_valid_nxt = 1'b1;
          job_pat_nxt   = enc.pat;
          job_rem_nxt   = enc.len;
        end else if (in_tdata == CHR_SPACE) begin
          job_valid_nxt = 1'b1;
        end
      end else if (is_elem) begin
        if (grp_len_r < 3'(MAX_ELEMENTS)) begin
          grp_pat_nxt = {grp_pat_r[3:0], in_tdata == CHR_DASH};
          grp_len_nxt = grp_len_r + 3'd1;
        end else begin
          grp_bad_nxt = 1'b1;
        end
      end else if (in_tdata != CHR_SPACE) begin
        grp_bad_nxt = 1'b1;
      end else begin
        job_valid_nxt = !grp_bad_r && (grp_len_r != 3'd0) && dec.hit;
        job_char_nxt  = dec.chr;
        grp_pat_nxt   = '0;
        grp_len_nxt   = '0;
        grp_bad_nxt   = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (job_rem_r != 3'd0) begin
        out_data_nxt = job_pat_r[4] ? CHR_DASH : CHR_DOT;
        out_last_nxt = 1'b0;
      end else begin
        out_data_nxt = job_char_r;
        out_last_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      grp_pat_r   <= '0;
      grp_len_r   <= '0;
      grp_bad_r   <= 1'b0;
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        direction_r <= cfg_data;
      end
      grp_pat_r   <= grp_pat_nxt;
      grp_len_r   <= grp_len_nxt;
      grp_bad_r   <= grp_bad_nxt;
      job_valid_r <= job_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_pat_r  <= job_pat_nxt;
    job_rem_r  <= job_rem_nxt;
    job_char_r <= job_char_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire

[sim/morse_code_codec_unit_tb.sv]
// Self-checking testbench for the Morse code codec unit, encode and decode directions.
`timescale 1ns / 1ps
module morse_code_codec_unit_tb;
  import mcc_pkg::*;

  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } beat_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  logic [7:0] tx_chars [$];
  beat_t      due_beats [$];
  int         mismatches;
  logic       quiet;
  logic       hold_off;
  logic       pressure_on;

  logic       dir_now;
  logic [4:0] grp_pat;
  logic [2:0] grp_len;
  logic       grp_bad;

  morse_code_codec_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // {length[2:0], elements[4:0]}, newest element in bit 0, dash is 1
  function automatic logic [7:0] morse_entry(input int k);
    case (k)
      0: return 8'h41;  1: return 8'h88;  2: return 8'h8A;  3: return 8'h64;
      4: return 8'h20;  5: return 8'h82;  6: return 8'h66;  7: return 8'h80;
      8: return 8'h40;  9: return 8'h87; 10: return 8'h65; 11: return 8'h84;
      12: return 8'h43; 13: return 8'h42; 14: return 8'h67; 15: return 8'h86;
      16: return 8'h8D; 17: return 8'h62; 18: return 8'h60; 19: return 8'h21;
      20: return 8'h61; 21: return 8'h81; 22: return 8'h63; 23: return 8'h89;
      24: return 8'h8B; 25: return 8'h8C; 26: return 8'hBF; 27: return 8'hAF;
      28: return 8'hA7; 29: return 8'hA3; 30: return 8'hA1; 31: return 8'hA0;
      32: return 8'hB0; 33: return 8'hB8; 34: return 8'hBC; 35: return 8'hBE;
      default: return 8'h00;
    endcase
  endfunction

  function automatic beat_t mk_beat(input logic [7:0] c, input logic l);
    beat_t b;
    b.chr  = c;
    b.last = l;
    return b;
  endfunction

  task automatic translate_char(input logic [7:0] c);
    int         k;
    int         i;
    logic [7:0] ent;
    logic       found;
    k     = -1;
    found = 1'b0;
    if (!dir_now) begin
      if (c >= "A" && c <= "Z") k = int'(c - LETTER_BASE);
      else if (c >= "a" && c <= "z") k = int'(c - LOWER_BASE);
      else if (c >= "0" && c <= "9") k = 26 + int'(c - DIGIT_BASE);
      if (k >= 0) begin
        ent = morse_entry(k);
        for (i = int'(ent[7:5]) - 1; i >= 0; i--) begin
          due_beats.push_back(mk_beat(ent[i] ? CHR_DASH : CHR_DOT, 1'b0));
        end
        due_beats.push_back(mk_beat(CHR_SPACE, 1'b1));
      end else if (c == CHR_SPACE) begin
        due_beats.push_back(mk_beat(CHR_SPACE, 1'b1));
      end
    end else if (c == CHR_DOT || c == CHR_DASH) begin
      if (grp_len < 3'd5) begin
        grp_pat = {grp_pat[3:0], c == CHR_DASH};
        grp_len = grp_len + 3'd1;
      end else begin
        grp_bad = 1'b1;
      end
    end else if (c != CHR_SPACE) begin
      grp_bad = 1'b1;
    end else begin
      if (!grp_bad && grp_len != 3'd0) begin
        for (k = 0; k < 36; k++) begin
          ent = morse_entry(k);
          if (!found && ent[7:5] == grp_len && ent[4:0] == grp_pat) begin
            found = 1'b1;
            due_beats.push_back(mk_beat(k < 26 ? LETTER_BASE + 8'(k)
                                               : DIGIT_BASE + 8'(k - 26), 1'b1));
          end
        end
      end
      grp_pat = '0;
      grp_len = '0;
      grp_bad = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) translate_char(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (tx_chars.size() != 0 && (quiet || $urandom_range(0, 99) >= 24)) begin
          in_tdata  <= tx_chars.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic flag_mismatch(input beat_t want, input beat_t got, input bit orphan);
    mismatches++;
    if (mismatches <= 10) begin
      if (orphan)
        $display("unexpected beat: char %h last %b", got.chr, got.last);
      else
        $display("beat mismatch: expected char %h last %b, got char %h last %b",
                 want.chr, want.last, got.chr, got.last);
    end
  endtask

  always @(posedge clk) begin
    beat_t want;
    beat_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = mk_beat(out_tdata, out_tlast);
        if (due_beats.size() == 0) begin
          flag_mismatch(got, got, 1'b1);
        end else begin
          want = due_beats.pop_front();
          if (want.chr !== got.chr || want.last !== got.last) flag_mismatch(want, got, 1'b0);
        end
      end
      out_tready <= !hold_off && (quiet || $urandom_range(0, 99) >= 24);
    end
  end

  // long receiver hold-off, counted here
  initial begin
    hold_off = 1'b0;
    wait (pressure_on);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic wait_idle();
    do @(negedge clk); while (tx_chars.size() != 0 || in_tvalid || due_beats.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_direction(input logic d);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dir_now = d;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) tx_chars.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'($urandom);
    if (r < 30) return CHR_SPACE;
    r = $urandom_range(0, 61);
    if (r < 26) return LETTER_BASE + 8'(r);
    if (r < 52) return LOWER_BASE + 8'(r - 26);
    return DIGIT_BASE + 8'(r - 52);
  endfunction

  function automatic logic [7:0] rand_element();
    return $urandom_range(0, 1) ? CHR_DASH : CHR_DOT;
  endfunction

  task automatic send_random_group();
    int         r;
    int         n;
    int         i;
    logic [7:0] ent;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      if (r >= 65) tx_chars.push_back(8'($urandom));
      ent = morse_entry($urandom_range(0, 35));
      for (i = int'(ent[7:5]) - 1; i >= 0; i--) tx_chars.push_back(ent[i] ? CHR_DASH : CHR_DOT);
    end else if (r < 85) begin
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) tx_chars.push_back(rand_element());
    end else if (r < 93) begin
      n = $urandom_range(6, 8);
      for (i = 0; i < n; i++) tx_chars.push_back(rand_element());
    end
    tx_chars.push_back(CHR_SPACE);
  endtask

  initial begin
    int i;
    mismatches  = 0;
    quiet       = 1'b0;
    pressure_on = 1'b0;
    dir_now     = 1'b0;
    grp_pat     = '0;
    grp_len     = '0;
    grp_bad     = 1'b0;
    rst_n       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_direction(1'b0);
    send_str("AZaz09 5@[`{/:");
    tx_chars.push_back(8'h00);
    tx_chars.push_back(8'hFF);
    for (i = 0; i < 80; i++) tx_chars.push_back(rand_text_char());

    wait_idle();
    @(posedge clk);
    quiet       <= 1'b1;
    pressure_on = 1'b1;
    for (i = 0; i < 40; i++) tx_chars.push_back(DIGIT_BASE + 8'($urandom_range(0, 9)));
    wait_idle();
    quiet <= 1'b0;
    @(negedge clk);

    set_direction(1'b1);
    send_str(".- ----- --.. ...... ...---... .x ..-- -.-.-   ");
    tx_chars.push_back(8'hFF);
    send_str(" -.");
    set_direction(1'b0);
    send_str("E");
    set_direction(1'b1);
    send_str(" ");
    for (i = 0; i < 20; i++) send_random_group();
    wait_idle();
    @(posedge clk);
    quiet <= 1'b1;
    for (i = 0; i < 10; i++) send_random_group();
    wait_idle();
    quiet <= 1'b0;
    @(negedge clk);

    set_direction(1'b0);
    for (i = 0; i < 30; i++) tx_chars.push_back(rand_text_char());
    set_direction(1'b1);
    for (i = 0; i < 10; i++) send_random_group();

    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && due_beats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
